### src/assert_macros.svh
// assertion macros used by the back end of the slew limiter
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define DDS_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

`define DDS_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define DDS_ASSERT(name, clk, rst_n, prop)

`define DDS_NEVER(name, clk, rst_n, cond)

`endif

`endif

### src/dds_pkg.sv
// types, register codes and arithmetic helpers of the slew limiter
// no dependencies; used by the interfaces and every module
package dds_pkg;

	localparam int RATE_W = 16;
	localparam int ACC_W  = 23;
	localparam int MUL_W  = 49;
	localparam int IDX_W  = 3;

	// register indexes of the configuration port
	localparam logic [IDX_W-1:0] REG_INV_RADIUS  = 3'd0;
	localparam logic [IDX_W-1:0] REG_ICR_OFFSET  = 3'd1;
	localparam logic [IDX_W-1:0] REG_T_SCALE     = 3'd2;
	localparam logic [IDX_W-1:0] REG_S_SCALE     = 3'd3;
	localparam logic [IDX_W-1:0] REG_T_LIMIT     = 3'd4;
	localparam logic [IDX_W-1:0] REG_S_LIMIT     = 3'd5;

	// floor(x / 50) == (x * STEP_MUL) >> STEP_SHIFT for x below 2^17
	localparam logic [17:0] STEP_MUL   = 18'd167773;
	localparam int          STEP_SHIFT = 23;
	localparam logic [16:0] STEP_HALF  = 17'd25;
	localparam logic signed [7:0] TICKS = 8'sd50;

	typedef struct packed {
		logic        [15:0] inverse_radius;
		logic signed [15:0] icr_offset;
		logic signed [15:0] throttle_scale;
		logic signed [15:0] steer_scale;
		logic        [15:0] throttle_accel_limit;
		logic        [15:0] steer_accel_limit;
	} dds_cfg_t;

	// job handed from the front to the back
	typedef struct packed {
		logic signed [RATE_W-1:0] t_target;
		logic signed [RATE_W-1:0] turn_rate;
	} dds_job_t;

	typedef struct packed {
		logic signed [RATE_W-1:0] rate;
		logic signed [ACC_W-1:0]  req;
		logic                     clip;
	} dds_slew_t;

	// round to nearest (halves up) by 8 or 16 bits, then saturate to 16 bits
	function automatic logic signed [RATE_W-1:0] round_sat(
		input logic signed [MUL_W-1:0] v,
		input logic                    wide
	);
		logic signed [MUL_W:0] t;
		logic signed [MUL_W:0] s;
		t = wide ? ({v[MUL_W-1], v} + 50'sd32768) : ({v[MUL_W-1], v} + 50'sd128);
		s = wide ? (t >>> 16) : (t >>> 8);
		if (s > 50'sd32767)
			return 16'sh7fff;
		else if (s < -50'sd32768)
			return 16'sh8000;
		else
			return s[RATE_W-1:0];
	endfunction

	// acceleration limit on one wheel rate
	function automatic dds_slew_t slew(
		input logic signed [RATE_W-1:0] target,
		input logic signed [RATE_W-1:0] prev,
		input logic        [15:0]       limit
	);
		dds_slew_t           r;
		logic signed [16:0]  tx;
		logic signed [16:0]  px;
		logic signed [16:0]  diff;
		logic        [16:0]  mt;
		logic        [16:0]  mp;
		logic signed [ACC_W-1:0] req;
		logic        [ACC_W-1:0] mreq;
		logic        [34:0]  step_p;
		logic        [15:0]  step;
		tx = {target[15], target};
		px = {prev[15], prev};
		diff = tx - px;
		req = ACC_W'(diff) * ACC_W'(TICKS);
		mt = tx[16] ? 17'(-tx) : 17'(tx);
		mp = px[16] ? 17'(-px) : 17'(px);
		mreq = req[ACC_W-1] ? ACC_W'(-req) : ACC_W'(req);
		step_p = 35'({1'b0, limit} + STEP_HALF) * 35'(STEP_MUL);
		step = 16'(step_p >> STEP_SHIFT);
		r.req = req;
		r.clip = (mt > mp) && (mreq > {7'd0, limit});
		if (!r.clip)
			r.rate = target;
		else if (diff[16])
			r.rate = prev - $signed(step);
		else
			r.rate = prev + $signed(step);
		return r;
	endfunction

endpackage

### src/dds_if.sv
// channel interfaces of the slew limiter: commands, results, register writes
// depends on dds_pkg
interface dds_cmd_if;
	import dds_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [RATE_W-1:0] lin_speed;
	logic signed [RATE_W-1:0] turn_rate;
	modport source (output valid, lin_speed, turn_rate, input ready);
	modport sink (input valid, lin_speed, turn_rate, output ready);
endinterface

interface dds_res_if;
	import dds_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [RATE_W-1:0] throttle_out;
	logic signed [RATE_W-1:0] steering_out;
	logic signed [ACC_W-1:0]  throttle_req_accel;
	logic signed [ACC_W-1:0]  steer_req_accel;
	logic                     throttle_clipped;
	logic                     steering_clipped;
	modport source (output valid, throttle_out, steering_out, throttle_req_accel,
		steer_req_accel, throttle_clipped, steering_clipped, input ready);
	modport sink (input valid, throttle_out, steering_out, throttle_req_accel,
		steer_req_accel, throttle_clipped, steering_clipped, output ready);
endinterface

interface dds_cfg_if;
	import dds_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] index;
	logic [15:0]      data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### src/dds_front.sv
// front end: accepts commands and works out the throttle target rate
// depends on dds_pkg and dds_if
module dds_front (
	dds_cmd_if.sink            cmd,
	input  dds_pkg::dds_cfg_t  cfg,
	input  logic               q_full,
	output logic               push,
	output dds_pkg::dds_job_t  job
);
	import dds_pkg::*;

	logic signed [32:0] t_prod;

	assign cmd.ready = !q_full;
	assign push = cmd.valid && !q_full;

	assign t_prod = cmd.lin_speed * $signed({1'b0, cfg.inverse_radius});

	always_comb begin
		job.t_target = round_sat(MUL_W'(t_prod), 1'b0);
		job.turn_rate = cmd.turn_rate;
	end

endmodule

### src/dds_fifo.sv
// two-entry queue between the front and the back end
// depends on dds_pkg
module dds_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dds_pkg::dds_job_t push_job,
	input  logic              pop,
	output dds_pkg::dds_job_t head,
	output logic              empty,
	output logic              full
);
	import dds_pkg::*;

	dds_job_t   entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign empty = (count_q == 2'd0);
	assign full = (count_q == 2'd2);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_job;
	end

endmodule

### src/dds_back.sv
// back end: steering kinematics, slew limits and percent scaling
// on one shared multiplier; depends on dds_pkg, dds_if and assert_macros.svh
`include "assert_macros.svh"

module dds_back (
	input  logic              clk,
	input  logic              arst_n,
	input  dds_pkg::dds_cfg_t cfg,
	input  dds_pkg::dds_job_t head,
	input  logic              empty,
	output logic              pop,
	dds_res_if.source         res
);
	import dds_pkg::*;

	localparam logic [1:0] PH_KIN   = 2'd0;
	localparam logic [1:0] PH_STEER = 2'd1;
	localparam logic [1:0] PH_TPCT  = 2'd2;
	localparam logic [1:0] PH_SPCT  = 2'd3;

	logic                     busy_q;
	logic [1:0]               ph_q;
	logic                     res_valid_q;
	logic signed [RATE_W-1:0] prev_t_q;
	logic signed [RATE_W-1:0] prev_s_q;

	dds_job_t                 job_q;
	logic signed [31:0]       p_q;
	logic signed [RATE_W-1:0] s_target_q;
	logic signed [RATE_W-1:0] t_rate_q;
	logic signed [RATE_W-1:0] s_rate_q;
	logic signed [RATE_W-1:0] t_pct_q;
	logic signed [ACC_W-1:0]  t_req_q;
	logic signed [ACC_W-1:0]  s_req_q;
	logic                     t_clip_q;
	logic                     s_clip_q;

	logic signed [31:0]       mul_a;
	logic signed [16:0]       mul_b;
	logic signed [MUL_W-1:0]  prod;
	logic signed [RATE_W-1:0] prod_rnd;
	dds_slew_t                t_slew;
	dds_slew_t                s_slew;
	logic                     done;

	// operand selection for the shared multiplier
	always_comb begin
		case (ph_q)
			PH_KIN: begin
				mul_a = {{16{job_q.turn_rate[15]}}, job_q.turn_rate};
				mul_b = {cfg.icr_offset[15], cfg.icr_offset};
			end
			PH_STEER: begin
				mul_a = p_q;
				mul_b = {1'b0, cfg.inverse_radius};
			end
			PH_TPCT: begin
				mul_a = {{16{t_rate_q[15]}}, t_rate_q};
				mul_b = {cfg.throttle_scale[15], cfg.throttle_scale};
			end
			default: begin
				mul_a = {{16{s_rate_q[15]}}, s_rate_q};
				mul_b = {cfg.steer_scale[15], cfg.steer_scale};
			end
		endcase
	end

	assign prod = mul_a * mul_b;
	// the steering product of three factors drops 16 bits, the others 8
	assign prod_rnd = round_sat(prod, ph_q == PH_STEER);

	assign t_slew = slew(job_q.t_target, prev_t_q, cfg.throttle_accel_limit);
	assign s_slew = slew(s_target_q, prev_s_q, cfg.steer_accel_limit);

	assign done = busy_q && (ph_q == PH_SPCT) && (!res_valid_q || res.ready);
	assign pop = !empty && (!busy_q || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q <= PH_KIN;
			res_valid_q <= 1'b0;
			prev_t_q <= '0;
			prev_s_q <= '0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				ph_q <= PH_KIN;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (busy_q && ph_q != PH_SPCT) begin
				ph_q <= ph_q + 2'd1;
			end
			if (done)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
			if (busy_q && ph_q == PH_KIN)
				prev_t_q <= t_slew.rate;
			if (busy_q && ph_q == PH_TPCT)
				prev_s_q <= s_slew.rate;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= head;
		if (busy_q) begin
			case (ph_q)
				PH_KIN: begin
					p_q <= prod[31:0];
					t_rate_q <= t_slew.rate;
					t_req_q <= t_slew.req;
					t_clip_q <= t_slew.clip;
				end
				PH_STEER: begin
					s_target_q <= prod_rnd;
				end
				PH_TPCT: begin
					t_pct_q <= prod_rnd;
					s_rate_q <= s_slew.rate;
					s_req_q <= s_slew.req;
					s_clip_q <= s_slew.clip;
				end
				default: begin
					if (done) begin
						res.throttle_out <= t_pct_q;
						res.steering_out <= prod_rnd;
						res.throttle_req_accel <= t_req_q;
						res.steer_req_accel <= s_req_q;
						res.throttle_clipped <= t_clip_q;
						res.steering_clipped <= s_clip_q;
					end
				end
			endcase
		end
	end

	assign res.valid = res_valid_q;

	`DDS_ASSERT(a_rise_after_last, clk, arst_n,
		$rose(res_valid_q) |-> $past(busy_q && ph_q == PH_SPCT))
	`DDS_ASSERT(a_phase_advance, clk, arst_n,
		(busy_q && ph_q != PH_SPCT) |=> (busy_q && ph_q == $past(ph_q) + 2'd1))
	`DDS_NEVER(a_clip_without_accel, clk, arst_n,
		res_valid_q && res.throttle_clipped && res.throttle_req_accel == '0)

endmodule

### src/diff_drive_slew_limiter.sv
// top level of the differential drive slew limiter: register file and wiring
// depends on dds_pkg, dds_if, dds_front, dds_fifo and dds_back
//
// Usage:
//   cmd carries one drive command (lin_speed, turn_rate, signed Q8.8) per item.
//   res returns one item per command: throttle and steering percent, the
//   requested accelerations before limiting and the two clipped flags.
//   cfg writes register <index> with <data>; it is always ready, and writes
//   to an index of six or more are dropped. Write only while no item is open.
// Timing:
//   an item accepted on cmd is written into the queue. The back end runs
//   four steps on one shared multiplier; while busy it pops the next item
//   only in its last step. The front computes the throttle target as it
//   accepts and parks the item in a two-entry queue.
// Reset:
//   registers return to their defaults, the stored wheel rates go to zero
//   and the queue and the result register empty.
// Stall:
//   a stalled receiver holds the result register; the back end waits in its
//   last step and cmd keeps taking items until the queue fills.
module diff_drive_slew_limiter (
	input  logic      clk,
	input  logic      arst_n,
	dds_cmd_if.sink   cmd,
	dds_cfg_if.sink   cfg,
	dds_res_if.source res
);
	import dds_pkg::*;

	dds_cfg_t cfg_q;
	dds_job_t push_job;
	dds_job_t head;
	logic     push;
	logic     pop;
	logic     q_empty;
	logic     q_full;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inverse_radius <= 16'd256;
			cfg_q.icr_offset <= 16'sd256;
			cfg_q.throttle_scale <= 16'sd256;
			cfg_q.steer_scale <= 16'sd256;
			cfg_q.throttle_accel_limit <= 16'hffff;
			cfg_q.steer_accel_limit <= 16'hffff;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_INV_RADIUS: cfg_q.inverse_radius <= cfg.data;
				REG_ICR_OFFSET: cfg_q.icr_offset <= $signed(cfg.data);
				REG_T_SCALE:    cfg_q.throttle_scale <= $signed(cfg.data);
				REG_S_SCALE:    cfg_q.steer_scale <= $signed(cfg.data);
				REG_T_LIMIT:    cfg_q.throttle_accel_limit <= cfg.data;
				REG_S_LIMIT:    cfg_q.steer_accel_limit <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	dds_front u_front (
		.cmd    (cmd),
		.cfg    (cfg_q),
		.q_full (q_full),
		.push   (push),
		.job    (push_job)
	);

	dds_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	dds_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.empty  (q_empty),
		.pop    (pop),
		.res    (res)
	);

endmodule
